// ===== design/mec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int CoordW = 32;
	localparam int IterW  = 16;
	localparam int InFrac = 28;

	// Tags order the items in the ring; at most three are in flight.
	localparam int TagW = 2;

	// Escape radius squared (|z| > 20).
	localparam int EscapeSq = 400;

	// Control and sideband data of one ring slot.
	typedef struct packed {
		logic              valid;
		logic              done;
		logic [TagW-1:0]   tag;
		logic [IterW-1:0]  iter;
		logic [IterW-1:0]  index;
		logic [CoordW-1:0] c_real;
		logic [CoordW-1:0] c_imag;
	} mec_slot_t;

endpackage

`default_nettype wire

// ===== design/mandelbrot_escape_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each iteration passes once around a three-stage ring: partial products, product sum, update.
// Up to three points share the ring, and a new point can enter while others are still
// iterating. Results leave in input order.
// Reset clears the slot control of the ring, the tags and the output valid flag and sets the iteration limit to 80.

module mandelbrot_escape_count
	import mec_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,  // c_real [31:0], c_imag [63:32]
	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output      logic [15:0]  m_axis_tdata   // escape_index [15:0]
);

	// Internal coordinates carry twelve integer bits; squares carry RW bits.
	localparam int ZW  = FRAC_BITS + 12;
	localparam int RW  = 2 * ZW - FRAC_BITS;
	localparam int SHL = (FRAC_BITS >= InFrac) ? FRAC_BITS - InFrac : 0;
	localparam int SHR = (FRAC_BITS >= InFrac) ? 0 : InFrac - FRAC_BITS;
	localparam logic [RW:0] LIMIT = (RW + 1)'(EscapeSq) << FRAC_BITS;

	// Converts a Q4.28 input to the internal format, flooring when bits are dropped.
	function automatic logic [ZW-1:0] to_fix(input logic [CoordW-1:0] raw);
		logic signed [63:0] wide;
		wide = $signed({{(64 - CoordW){raw[CoordW-1]}}, raw});
		wide = (wide <<< SHL) >>> SHR;
		return wide[ZW-1:0];
	endfunction

	logic [IterW-1:0] max_iter_q;
	logic [TagW-1:0]  in_tag_q;
	logic [TagW-1:0]  out_tag_q;
	logic             out_valid_q;
	logic [IterW-1:0] out_index_q;

	mec_slot_t        slot_in;
	mec_slot_t        slot_s1;
	mec_slot_t        slot_s2;
	mec_slot_t        slot_s3;
	mec_slot_t        slot_upd;
	logic [ZW-1:0]    re_in;
	logic [ZW-1:0]    im_in;
	logic [ZW-1:0]    re_s3;
	logic [ZW-1:0]    im_s3;
	logic [ZW-1:0]    re_upd;
	logic [ZW-1:0]    im_upd;

	logic [2*ZW-1:0]  p_rr;
	logic [2*ZW-1:0]  p_ii;
	logic [2*ZW-1:0]  p_ri;
	logic [RW-1:0]    re2;
	logic [RW-1:0]    im2;
	logic [ZW-1:0]    rim2;
	logic [ZW-1:0]    cr;
	logic [ZW-1:0]    ci;
	logic [RW:0]      mag2;
	logic [RW-1:0]    nre_w;
	logic             escape;

	logic             in_fire;
	logic             take_out;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= IterW'(80);
		end else if (cfg_wen) begin
			max_iter_q <= cfg_wdata;
		end
	end

	// A new point enters the slot at the ring's entry only when that slot is empty.
	assign s_axis_tready = !slot_s3.valid;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// The oldest finished item leaves when the output register can take it.
	assign take_out = slot_s3.valid && slot_s3.done && (slot_s3.tag == out_tag_q)
	                  && (!out_valid_q || m_axis_tready);

	// Ring entry: load a new point, free a finished slot, or pass the slot on.
	always_comb begin
		slot_in = slot_s3;
		re_in   = re_s3;
		im_in   = im_s3;
		if (in_fire) begin
			slot_in.valid  = 1'b1;
			slot_in.done   = (max_iter_q == '0);
			slot_in.tag    = in_tag_q;
			slot_in.iter   = IterW'(1);
			slot_in.index  = '0;
			slot_in.c_real = s_axis_tdata[CoordW-1:0];
			slot_in.c_imag = s_axis_tdata[2*CoordW-1:CoordW];
			re_in          = to_fix(s_axis_tdata[CoordW-1:0]);
			im_in          = to_fix(s_axis_tdata[2*CoordW-1:CoordW]);
		end else if (take_out) begin
			slot_in.valid = 1'b0;
		end
	end

	// Products of the current z: re*re, im*im and re*im.
	mec_mul #(.W(ZW)) u_mul_rr (.clk(clk), .a(re_in), .b(re_in), .p(p_rr));
	mec_mul #(.W(ZW)) u_mul_ii (.clk(clk), .a(im_in), .b(im_in), .p(p_ii));
	mec_mul #(.W(ZW)) u_mul_ri (.clk(clk), .a(re_in), .b(im_in), .p(p_ri));

	// Slot control travels alongside the multiplier stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
			slot_s2 <= '0;
		end else begin
			slot_s1 <= slot_in;
			slot_s2 <= slot_s1;
		end
	end

	// Floor of each product to the internal format; re*im is doubled by shifting one less.
	assign re2  = p_rr[2*ZW-1:FRAC_BITS];
	assign im2  = p_ii[2*ZW-1:FRAC_BITS];
	assign rim2 = p_ri[ZW+FRAC_BITS-2:FRAC_BITS-1];
	assign cr   = to_fix(slot_s2.c_real);
	assign ci   = to_fix(slot_s2.c_imag);

	// Escape test on the current z and the next z in the same stage.
	assign mag2   = {re2[RW-1], re2} + {im2[RW-1], im2};
	assign escape = $signed(mag2) > $signed(LIMIT);
	assign nre_w  = re2 - im2 + {{(RW - ZW){cr[ZW-1]}}, cr};

	always_comb begin
		slot_upd = slot_s2;
		re_upd   = nre_w[ZW-1:0];
		im_upd   = rim2 + ci;
		if (slot_s2.valid && !slot_s2.done) begin
			if (escape) begin
				slot_upd.done  = 1'b1;
				slot_upd.index = slot_s2.iter - IterW'(1);
			end else if (slot_s2.iter == max_iter_q) begin
				slot_upd.done  = 1'b1;
				slot_upd.index = '0;
			end else begin
				slot_upd.iter = slot_s2.iter + IterW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s3 <= '0;
		end else begin
			slot_s3 <= slot_upd;
		end
	end

	always_ff @(posedge clk) begin
		re_s3 <= re_upd;
		im_s3 <= im_upd;
	end

	// Tags and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q    <= '0;
			out_tag_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				in_tag_q <= in_tag_q + TagW'(1);
			end
			if (take_out) begin
				out_tag_q   <= out_tag_q + TagW'(1);
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			out_index_q <= slot_s3.index;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_index_q;

endmodule

`default_nettype wire

// ===== design/mec_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mec_mul #(
	parameter int W = 40
) (
	input  wire logic                  clk,
	input  wire logic signed [W-1:0]   a,
	input  wire logic signed [W-1:0]   b,
	output      logic        [2*W-1:0] p
);

	// Each operand is split into a signed upper half and an unsigned lower half.
	localparam int H  = (W + 1) / 2;
	localparam int HW = W - H;

	logic signed [HW-1:0]   a_hi;
	logic signed [HW-1:0]   b_hi;
	logic signed [H:0]      a_lo;
	logic signed [H:0]      b_lo;

	logic signed [2*HW-1:0] hh_s1;
	logic signed [W:0]      hl_s1;
	logic signed [W:0]      lh_s1;
	logic        [2*H-1:0]  ll_s1;

	logic        [2*W-1:0]  hh_x;
	logic        [2*W-1:0]  hl_x;
	logic        [2*W-1:0]  lh_x;
	logic        [2*W-1:0]  ll_x;
	logic        [2*W-1:0]  p_s2;

	assign a_hi = a[W-1:H];
	assign b_hi = b[W-1:H];
	assign a_lo = {1'b0, a[H-1:0]};
	assign b_lo = {1'b0, b[H-1:0]};

	// First stage: four partial products.
	always_ff @(posedge clk) begin
		hh_s1 <= a_hi * b_hi;
		hl_s1 <= a_hi * b_lo;
		lh_s1 <= a_lo * b_hi;
		ll_s1 <= a[H-1:0] * b[H-1:0];
	end

	// Second stage: align and sum the partial products into the exact product.
	assign hh_x = {{(2*H){hh_s1[2*HW-1]}}, hh_s1};
	assign hl_x = {{(W-1){hl_s1[W]}}, hl_s1};
	assign lh_x = {{(W-1){lh_s1[W]}}, lh_s1};
	assign ll_x = {{(2*HW){1'b0}}, ll_s1};

	always_ff @(posedge clk) begin
		p_s2 <= (hh_x << (2 * H)) + (hl_x << H) + (lh_x << H) + ll_x;
	end

	assign p = p_s2;

endmodule

`default_nettype wire

// ===== dv/mec_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels and the configuration port of the escape counter.
// Every input transfer is predicted at once, and every output transfer is matched
// against the oldest prediction that is still waiting.
module mec_checker
	import mec_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // c_real [31:0], c_imag [63:32]
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,   // escape_index [15:0]
	output int               fail_count,
	output int               outstanding
);

	localparam logic [IterW-1:0] DefaultIterLimit = IterW'(80);

	// Local copy of the iteration limit register.
	logic [IterW-1:0] iter_limit;

	// Escape indexes predicted for points that have entered but not yet left.
	logic [IterW-1:0] escape_queue[$];

	// Exact product, rounded toward minus infinity to FRAC_BITS fraction bits.
	function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [127:0] wide_a;
		logic signed [127:0] wide_b;
		logic signed [127:0] product;
		wide_a = a;
		wide_b = b;
		product = wide_a * wide_b;
		return product[FRAC_BITS+63:FRAC_BITS];
	endfunction

	// Converts a Q4.28 coordinate to the internal format.
	function automatic logic signed [63:0] widen_coord(input logic [CoordW-1:0] raw);
		logic signed [63:0] value;
		value = $signed(raw);
		if (FRAC_BITS >= InFrac) begin
			return value <<< (FRAC_BITS - InFrac);
		end
		return value >>> (InFrac - FRAC_BITS);
	endfunction

	// Iterates z = z*z + c from zero and returns the step at which |z| first exceeds 20.
	// A point that stays bounded, or a zero limit, gives 0.
	function automatic logic [IterW-1:0] escape_index(input logic [CoordW-1:0] c_real_raw,
			input logic [CoordW-1:0] c_imag_raw, input logic [IterW-1:0] limit);
		logic signed [63:0] c_re;
		logic signed [63:0] c_im;
		logic signed [63:0] re;
		logic signed [63:0] im;
		logic signed [63:0] re_sq;
		logic signed [63:0] im_sq;
		logic signed [63:0] next_re;
		logic signed [63:0] radius_sq;
		logic [IterW-1:0] index;
		int unsigned step;
		bit escaped;
		c_re = widen_coord(c_real_raw);
		c_im = widen_coord(c_imag_raw);
		radius_sq = EscapeSq;
		radius_sq = radius_sq <<< FRAC_BITS;
		re = 0;
		im = 0;
		re_sq = 0;
		im_sq = 0;
		index = 0;
		escaped = 0;
		for (step = 0; step < limit && !escaped; step++) begin
			next_re = re_sq - im_sq + c_re;
			im = fix_mul(re <<< 1, im) + c_im;
			re = next_re;
			re_sq = fix_mul(re, re);
			im_sq = fix_mul(im, im);
			if (re_sq + im_sq > radius_sq) begin
				index = step[IterW-1:0];
				escaped = 1;
			end
		end
		return index;
	endfunction

	// Track the register, predict on input transfers and compare on output transfers.
	always @(posedge clk or negedge arst_n) begin
		logic [IterW-1:0] expected;
		if (!arst_n) begin
			iter_limit <= DefaultIterLimit;
			escape_queue.delete();
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_wen) begin
				iter_limit <= cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (escape_queue.size() == 0) begin
					$error("escape_index: expected none, actual %0d", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					expected = escape_queue.pop_front();
					if (m_axis_tdata !== expected) begin
						$error("escape_index: expected %0d, actual %0d", expected, m_axis_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				escape_queue.push_back(escape_index(s_axis_tdata[31:0], s_axis_tdata[63:32],
					iter_limit));
			end
			outstanding <= escape_queue.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import mec_pkg::*;

	localparam int FracBits   = 28;
	localparam int PhaseItems = 200;
	localparam int QuietTail  = 150;
	localparam int LongHold   = 400;
	localparam int Limit      = 12_000_000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wen = 0;
	logic [15:0] cfg_wdata = 0;
	logic        s_axis_tvalid = 0;
	wire logic   s_axis_tready;
	logic [63:0] s_axis_tdata = 0;   // c_real [31:0], c_imag [63:32]
	wire logic   m_axis_tvalid;
	logic        m_axis_tready = 0;
	wire logic [15:0] m_axis_tdata;  // escape_index [15:0]

	int          fail_count;
	int          outstanding;
	int unsigned cycle_count = 0;
	bit          quiet = 0;
	bit          hold_request = 0;

	always #2 clk = ~clk;

	mandelbrot_escape_count #(
		.FRAC_BITS(FracBits)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	mec_checker #(
		.FRAC_BITS(FracBits)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// Offers one point until its transfer, then sometimes leaves a short gap.
	task automatic send_point(input logic [31:0] c_real, input logic [31:0] c_imag);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {c_imag, c_real};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every predicted escape index has come out.
	task automatic drain_results();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the iteration limit once the block is idle.
	task automatic set_iter_limit(input logic [15:0] value);
		drain_results();
		cfg_wen <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 0;
	endtask

	// Mostly points near the set, where escape times vary; the rest use every bit.
	function automatic logic [63:0] random_point();
		logic [31:0] re;
		logic [31:0] im;
		if ($urandom_range(0, 9) < 2) begin
			re = $urandom;
			im = $urandom;
		end else begin
			// Real part in [-2.25, 0.75], imaginary part in [-1.5, 1.5].
			re = $urandom_range(0, 32'd805306368) - 32'd603979776;
			im = $urandom_range(0, 32'd805306368) - 32'd402653184;
		end
		return {im, re};
	endfunction

	task automatic run_random(input int count, input bit quiet_end);
		logic [63:0] point;
		for (int i = 0; i < count; i++) begin
			if (quiet_end && i >= count - QuietTail) begin
				quiet = 1;
			end
			point = random_point();
			send_point(point[31:0], point[63:32]);
		end
	endtask

	// Output side: random ready runs and stall bursts, plus one long hold-off on request.
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				m_axis_tready <= 0;
				repeat (LongHold) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Watchdog on the total number of cycles.
	initial begin
		while (cycle_count < Limit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed points under the limit left by reset.
		send_point(32'h0000_0000, 32'h0000_0000);   // origin, never escapes
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // both parts at their maximum
		send_point(32'h8000_0000, 32'h8000_0000);   // both parts at their minimum
		send_point(32'h8000_0000, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h0000_0000, 32'h7FFF_FFFF);
		send_point(32'h2000_0000, 32'h0000_0000);   // 2.0
		send_point(32'hE000_0000, 32'h0000_0000);   // -2.0, on the edge of the set
		send_point(32'h1000_0000, 32'h0000_0000);   // 1.0
		send_point(32'h0000_0000, 32'h1000_0000);   // i, periodic orbit
		send_point(32'h0400_0000, 32'h0000_0000);   // 0.25, the cusp
		send_point(32'h0400_0100, 32'h0000_0000);   // just outside the cusp
		send_point(32'hF400_0000, 32'h0199_999A);   // -0.75 + 0.1i, slow escape
		send_point(32'hF000_0000, 32'h0000_0000);   // -1.0
		send_point(32'h04CC_CCCD, 32'h0000_0000);   // 0.3
		send_point(32'hFE66_6666, 32'h0A6A_7EF9);
		send_point(32'hE000_0001, 32'h0000_0000);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // smallest negative step
		send_point(32'h0666_6666, 32'h0999_9999);
		send_point(32'hF800_0000, 32'hF666_6667);

		// A zero limit runs no step at all.
		set_iter_limit(16'd0);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h2000_0000, 32'h0000_0000);

		// Largest limit: two bounded points and two that escape late or early.
		set_iter_limit(16'hFFFF);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'hF000_0000, 32'h0000_0000);
		send_point(32'h0400_0100, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);

		// Single-step limit with a long output hold-off, so the ring fills and stalls input.
		set_iter_limit(16'd1);
		hold_request = 1;
		run_random(PhaseItems, 0);

		set_iter_limit(16'd2);
		run_random(PhaseItems, 0);

		set_iter_limit(16'($urandom_range(16, 64)));
		run_random(PhaseItems, 0);

		set_iter_limit(16'($urandom_range(3, 300)));
		run_random(PhaseItems, 0);

		set_iter_limit(16'd255);
		run_random(PhaseItems, 0);

		// Back to the reset limit; the tail of this phase runs without idling.
		set_iter_limit(16'd80);
		run_random(PhaseItems, 1);

		drain_results();
		repeat (256) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/mec_pkg.sv
design/mec_mul.sv
design/mandelbrot_escape_count.sv
dv/mec_checker.sv
dv/tb_top.sv
